@@ sv/jbdi_pkg.sv @@
package jbdi_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 12;
  localparam int VAL_W = 40;
  localparam int ROW_W = 32;
  localparam int PIX_W = 8;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [15:0]        quant_step;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_of_block;
  } out_beat_t;

  typedef struct packed {
    logic       ld_we;
    logic [5:0] ld_idx;
    logic       col;
    logic [2:0] line;
    logic       rd;
    logic [2:0] rd_idx;
    logic       cap;
    logic [2:0] cap_idx;
    logic [4:0] st;
    logic       wr;
    logic [2:0] wr_idx;
    logic       em_rd;
    logic [5:0] em_idx;
    logic       em_last;
  } cmd_t;

  localparam logic [31:0] INV_SCALE_Q24 [8] = '{
    32'd47453133, 32'd65819386, 32'd62000506, 32'd55798981,
    32'd47453133, 32'd37283687, 32'd25681450, 32'd13092290
  };
  localparam logic [31:0] SQRT2_Q24  = 32'd23726566;
  localparam logic [31:0] ROT_A2_Q24 = 32'd9079764;
  localparam logic [31:0] ROT_A4_Q24 = 32'd21920489;
  localparam logic [31:0] ROT_A5_Q24 = 32'd6420363;

  function automatic logic [31:0] kq(input logic [31:0] k24, input int f);
    return (k24 + (32'd1 << (23 - f))) >> (24 - f);
  endfunction

endpackage

@@ sv/jbdi_ctrl.sv @@
module jbdi_ctrl
  import jbdi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_LINE = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  localparam logic [4:0] STEP_LAST = 5'd21;
  localparam logic [4:0] STEP_ST0  = 5'd9;
  localparam logic [4:0] STEP_WR0  = 5'd14;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       col, col_next;
  logic [2:0] line, line_next;
  logic [4:0] step, step_next;

  assign busy = (state != S_LOAD);

  always_comb begin
    cmd         = '0;
    cmd.ld_idx  = cnt;
    cmd.ld_we   = (state == S_LOAD) && start;
    cmd.col     = col;
    cmd.line    = line;
    cmd.rd      = (state == S_LINE) && (step < 5'd8);
    cmd.rd_idx  = step[2:0];
    cmd.cap     = (state == S_LINE) && (step >= 5'd1) && (step <= 5'd8);
    cmd.cap_idx = 3'(step - 5'd1);
    for (int i = 0; i < 5; i++) begin
      cmd.st[i] = (state == S_LINE) && (step == STEP_ST0 + 5'(i));
    end
    cmd.wr      = (state == S_LINE) && (step >= STEP_WR0);
    cmd.wr_idx  = 3'(step - STEP_WR0);
    cmd.em_rd   = (state == S_EMIT);
    cmd.em_idx  = cnt;
    cmd.em_last = (cnt == 6'd63);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    col_next   = col;
    line_next  = line;
    step_next  = step;
    unique case (state)
      S_LOAD: begin
        if (start) begin
          cnt_next = cnt + 6'd1;
          if (cnt == 6'd63) begin
            state_next = S_LINE;
            col_next   = 1'b0;
            line_next  = 3'd0;
            step_next  = 5'd0;
          end
        end
      end
      S_LINE: begin
        step_next = step + 5'd1;
        if (step == STEP_LAST) begin
          step_next = 5'd0;
          line_next = line + 3'd1;
          if (line == 3'd7) begin
            if (col) begin
              state_next = S_EMIT;
              cnt_next   = 6'd0;
            end else begin
              col_next = 1'b1;
            end
          end
        end
      end
      S_EMIT: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      col   <= 1'b0;
      line  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      col   <= col_next;
      line  <= line_next;
      step  <= step_next;
    end
  end

endmodule

@@ sv/jbdi_dpath.sv @@
module jbdi_dpath
  import jbdi_pkg::*;
#(
  parameter int COEF_BITS     = COEF_BITS_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_beat_t  item,
  output logic      strobe,
  output out_beat_t result
);

  localparam int KW = FRACTION_BITS + 4;
  localparam int PW = VAL_W + KW;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [KW-1:0] k_t;

  function automatic k_t kc(input logic [31:0] k24);
    return k_t'(kq(k24, FRACTION_BITS));
  endfunction

  localparam k_t KSC [8] = '{
    kc(INV_SCALE_Q24[0]), kc(INV_SCALE_Q24[1]), kc(INV_SCALE_Q24[2]), kc(INV_SCALE_Q24[3]),
    kc(INV_SCALE_Q24[4]), kc(INV_SCALE_Q24[5]), kc(INV_SCALE_Q24[6]), kc(INV_SCALE_Q24[7])
  };
  localparam k_t K_S2 = kc(SQRT2_Q24);
  localparam k_t K_A2 = kc(ROT_A2_Q24);
  localparam k_t K_A4 = kc(ROT_A4_Q24);
  localparam k_t K_A5 = kc(ROT_A5_Q24);

  function automatic val_t fmul(input val_t x, input k_t k);
    logic signed [PW-1:0] p;
    p = PW'(x) * PW'(k);
    return val_t'(p >>> FRACTION_BITS);
  endfunction

  function automatic val_t hv(input val_t v);
    return v >>> 1;
  endfunction

  // dequantize and saturate
  localparam logic signed [32:0] PMAX = (33'sd1 <<< (COEF_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] PMIN = -PMAX - 33'sd1;

  logic signed [32:0]          prod;
  logic signed [COEF_BITS-1:0] coef_sat;

  always_comb begin
    prod = 33'(item.coefficient) * $signed({17'd0, item.quant_step});
    if (prod > PMAX) begin
      coef_sat = PMAX[COEF_BITS-1:0];
    end else if (prod < PMIN) begin
      coef_sat = PMIN[COEF_BITS-1:0];
    end else begin
      coef_sat = prod[COEF_BITS-1:0];
    end
  end

  logic signed [COEF_BITS-1:0] coef_mem [64];
  logic signed [COEF_BITS-1:0] coef_q;
  logic signed [ROW_W-1:0]     row_mem [64];
  logic signed [ROW_W-1:0]     row_q;
  logic [PIX_W-1:0]            pix_mem [64];

  val_t a [8];
  val_t d53, d17, s17, s53, ev_s, ev_d, dc_s, dc_d;
  val_t hi, hd, rot, m4, m2, em;
  val_t g12, o6, mhd, e10, e0, e3;
  val_t o5, o4, e1, e2;
  val_t y [8];

  val_t                    x_in;
  val_t                    yw;
  val_t                    tr;
  logic signed [ROW_W-1:0] row_sat;
  logic [PIX_W-1:0]        pix_val;

  localparam val_t RMAX = val_t'(64'sh7fffffff);
  localparam val_t RMIN = -RMAX - val_t'(1);
  localparam val_t HALF = val_t'(1) <<< (FRACTION_BITS - 1);

  always_comb begin
    if (cmd.col) begin
      x_in = val_t'(row_q);
    end else begin
      x_in = val_t'(coef_q) <<< FRACTION_BITS;
    end
    yw = y[cmd.wr_idx];
    if (yw > RMAX) begin
      row_sat = RMAX[ROW_W-1:0];
    end else if (yw < RMIN) begin
      row_sat = RMIN[ROW_W-1:0];
    end else begin
      row_sat = yw[ROW_W-1:0];
    end
    tr = (yw + HALF) >>> FRACTION_BITS;
    if (tr < -val_t'(128)) begin
      pix_val = 8'd0;
    end else if (tr > val_t'(127)) begin
      pix_val = 8'd255;
    end else begin
      pix_val = 8'(tr + val_t'(128));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      coef_mem[cmd.ld_idx] <= coef_sat;
    end
    if (cmd.rd) begin
      coef_q <= coef_mem[{cmd.line, cmd.rd_idx}];
      row_q  <= row_mem[{cmd.rd_idx, cmd.line}];
    end
    if (cmd.wr && !cmd.col) begin
      row_mem[{cmd.line, cmd.wr_idx}] <= row_sat;
    end
    if (cmd.wr && cmd.col) begin
      pix_mem[{cmd.wr_idx, cmd.line}] <= pix_val;
    end
    if (cmd.em_rd) begin
      result.pixel         <= pix_mem[cmd.em_idx];
      result.last_of_block <= cmd.em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      a[cmd.cap_idx] <= fmul(x_in, KSC[cmd.cap_idx]);
    end
    if (cmd.st[0]) begin
      d53  <= hv(a[5] - a[3]);
      d17  <= hv(a[1] - a[7]);
      s17  <= hv(a[1] + a[7]);
      s53  <= hv(a[5] + a[3]);
      ev_s <= hv(a[2] + a[6]);
      ev_d <= hv(a[2] - a[6]);
      dc_s <= hv(a[0] + a[4]);
      dc_d <= hv(a[0] - a[4]);
    end
    if (cmd.st[1]) begin
      hi  <= hv(s17 + s53);
      hd  <= hv(s17 - s53);
      rot <= fmul(d53 - d17, K_A5);
      m4  <= fmul(d53, K_A4);
      m2  <= fmul(d17, K_A2);
      em  <= fmul(ev_d, K_S2);
    end
    if (cmd.st[2]) begin
      g12 <= rot - m4;
      o6  <= (m2 - rot) - hi;
      mhd <= fmul(hd, K_S2);
      e10 <= em - ev_s;
      e0  <= hv(dc_s + ev_s);
      e3  <= hv(dc_s - ev_s);
    end
    if (cmd.st[3]) begin
      o5 <= mhd - o6;
      o4 <= (o6 - mhd) - g12;
      e1 <= hv(dc_d + e10);
      e2 <= hv(dc_d - e10);
    end
    if (cmd.st[4]) begin
      y[0] <= hv(e0 + hi);
      y[1] <= hv(e1 + o6);
      y[2] <= hv(e2 + o5);
      y[3] <= hv(e3 + o4);
      y[4] <= hv(e3 - o4);
      y[5] <= hv(e2 - o5);
      y[6] <= hv(e1 - o6);
      y[7] <= hv(e0 - hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.em_rd;
    end
  end

endmodule

@@ sv/jpeg_block_dequant_idct.sv @@
// channel   signals                       beat taken when
// in        start, busy, item             start high and busy low
// out       strobe, result                strobe high, no stall
//
// coefficients load at one per cycle while start is high and busy is low
// the 64th beat raises busy: 16 line passes, each through one
// shared line unit (8 memory reads, 5 arithmetic stages, 8 writes)
// then 64 pixels leave in raster order, one per cycle, from the pixel memory
// synchronous reset returns to the load phase with the count at zero
module jpeg_block_dequant_idct
  import jbdi_pkg::*;
#(
  parameter int COEF_BITS     = COEF_BITS_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  item,
  output logic      strobe,
  output out_beat_t result
);

  cmd_t cmd;

  jbdi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  jbdi_dpath #(
    .COEF_BITS     (COEF_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

endmodule
